// File: rtl/decimal_display_formatter_assert.svh
// Assertion macros used by the decimal display formatter RTL.
`ifndef DECIMAL_DISPLAY_FORMATTER_ASSERT_SVH
`define DECIMAL_DISPLAY_FORMATTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ddf_pkg.sv
// Types, codes, constants and the power-of-ten table for the decimal display formatter.
package ddf_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 4;
  localparam int unsigned ExpW  = 4;

  // Format commands.
  localparam logic [1:0] CMD_U10 = 2'd0;
  localparam logic [1:0] CMD_U5  = 2'd1;
  localparam logic [1:0] CMD_S6  = 2'd2;

  // Leading exponent of each format.
  localparam logic [ExpW-1:0] EXP_U10 = 4'd9;
  localparam logic [ExpW-1:0] EXP_U5  = 4'd4;
  localparam logic [ExpW-1:0] EXP_S6  = 4'd5;

  localparam logic [CharW-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CharW-1:0] CHAR_SPACE = 8'd32;

  typedef struct packed {
    logic [1:0]       command;
    logic [WordW-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic [PosW-1:0]  position;
    logic             last;
  } out_beat_t;

  // Status handed from the divider back to the sequencer.
  typedef struct packed {
    logic             done;
    logic             q_nz;
    logic [CharW-1:0] q_low;
  } div_res_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  function automatic logic [WordW-1:0] pow10(input logic [ExpW-1:0] e);
    logic [WordW-1:0] p;
    unique case (e)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/ddf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module ddf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ddf_pkg::WordW-1:0]  dividend_i,
  input  logic [ddf_pkg::WordW-1:0]  divisor_i,
  output ddf_pkg::div_res_t          res_o,
  output logic [ddf_pkg::WordW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(ddf_pkg::WordW);
  localparam logic [CntW-1:0] CntLast = CntW'(ddf_pkg::WordW - 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [ddf_pkg::WordW-1:0]  n_q, n_d;
  logic [ddf_pkg::WordW-1:0]  r_q, r_d;
  logic [ddf_pkg::WordW-1:0]  d_q, d_d;
  logic [ddf_pkg::CharW-1:0]  q_q, q_d;
  logic                       nz_q, nz_d;
  logic [ddf_pkg::WordW:0]    trial;
  logic                       ge;

  assign trial = {r_q, n_q[ddf_pkg::WordW-1]};
  assign ge    = trial >= {1'b0, d_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    r_d    = r_q;
    d_d    = d_q;
    q_d    = q_q;
    nz_d   = nz_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
      q_d    = '0;
      nz_d   = 1'b0;
    end else if (busy_q) begin
      // Shift in the next dividend bit and subtract when it fits.
      r_d  = ge ? ddf_pkg::WordW'(trial - {1'b0, d_q}) : trial[ddf_pkg::WordW-1:0];
      n_d  = {n_q[ddf_pkg::WordW-2:0], 1'b0};
      q_d  = {q_q[ddf_pkg::CharW-2:0], ge};
      nz_d = nz_q | ge;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    r_q  <= r_d;
    d_q  <= d_d;
    q_q  <= q_d;
    nz_q <= nz_d;
  end

  assign res_o.done  = done_q;
  assign res_o.q_nz  = nz_q;
  assign res_o.q_low = q_q;
  assign rem_o       = r_q;

endmodule

// File: rtl/decimal_display_formatter.sv
// Each character costs one pass of the bit-serial divider, then the S_DIV and S_EMIT
// steps; S_EMIT waits while the output register holds a character not yet taken.
// A full item takes 10, 5 or 6 characters.
// The next input beat is taken once the final character sits in the output register.
// Reset is asynchronous and active low; it clears the sequencer and the output valid.
module decimal_display_formatter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ddf_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ddf_pkg::out_beat_t out_data_o
);

  `include "decimal_display_formatter_assert.svh"

  // Control state.
  ddf_pkg::state_e state_q, state_d;
  logic            start_q, start_d;
  logic            out_valid_q, out_valid_d;

  // Working payload for the item in flight.
  logic [ddf_pkg::WordW-1:0] rem_q, rem_d;
  logic [ddf_pkg::ExpW-1:0]  exp_q, exp_d;
  logic [ddf_pkg::PosW-1:0]  pos_q, pos_d;
  logic                      neg_q, neg_d;
  logic                      lead_q, lead_d;
  logic [ddf_pkg::CharW-1:0] pend_char_q, pend_char_d;
  ddf_pkg::out_beat_t        out_data_q, out_data_d;

  ddf_pkg::div_res_t         div_res;
  logic [ddf_pkg::WordW-1:0] div_rem;
  logic                      in_fire;
  logic                      is_last;

  // The divider splits the remaining value by the power of ten of the
  // current position; its remainder becomes the new remaining value.
  ddf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (rem_q),
    .divisor_i  (ddf_pkg::pow10(exp_q)),
    .res_o      (div_res),
    .rem_o      (div_rem)
  );

  assign in_ready_o = (state_q == ddf_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_last    = (exp_q == '0);

  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q;
    rem_d       = rem_q;
    exp_d       = exp_q;
    pos_d       = pos_q;
    neg_d       = neg_q;
    lead_d      = lead_q;
    pend_char_d = pend_char_q;
    out_data_d  = out_data_q;

    // The downstream side drains the output register independently.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ddf_pkg::S_IDLE: begin
        if (in_fire) begin
          pos_d  = '0;
          lead_d = 1'b1;
          neg_d  = 1'b0;
          rem_d  = in_data_i.value;
          unique case (in_data_i.command)
            ddf_pkg::CMD_U10: begin
              exp_d   = ddf_pkg::EXP_U10;
              start_d = 1'b1;
              state_d = ddf_pkg::S_DIV;
            end
            ddf_pkg::CMD_U5: begin
              exp_d   = ddf_pkg::EXP_U5;
              start_d = 1'b1;
              state_d = ddf_pkg::S_DIV;
            end
            ddf_pkg::CMD_S6: begin
              // Signed format works on the magnitude; the sign only
              // changes how leading blanks are drawn.
              exp_d   = ddf_pkg::EXP_S6;
              neg_d   = in_data_i.value[ddf_pkg::WordW-1];
              rem_d   = in_data_i.value[ddf_pkg::WordW-1] ? (-in_data_i.value)
                                                          : in_data_i.value;
              start_d = 1'b1;
              state_d = ddf_pkg::S_DIV;
            end
            default: begin
              // The unused command is dropped without output.
              state_d = ddf_pkg::S_IDLE;
            end
          endcase
        end
      end
      ddf_pkg::S_DIV: begin
        if (div_res.done) begin
          rem_d = div_rem;
          // A position is blank only while every quotient so far was zero,
          // and the final position always shows a digit.
          if (!lead_q || div_res.q_nz || is_last) begin
            pend_char_d = ddf_pkg::CHAR_ZERO + div_res.q_low;
            lead_d      = 1'b0;
          end else begin
            pend_char_d = neg_q ? ddf_pkg::CHAR_MINUS : ddf_pkg::CHAR_SPACE;
          end
          state_d = ddf_pkg::S_EMIT;
        end
      end
      ddf_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_data_d.character = pend_char_q;
          out_data_d.position  = pos_q;
          out_data_d.last      = is_last;
          pos_d                = pos_q + 1'b1;
          exp_d                = exp_q - 1'b1;
          if (is_last) begin
            state_d = ddf_pkg::S_IDLE;
          end else begin
            start_d = 1'b1;
            state_d = ddf_pkg::S_DIV;
          end
        end
      end
      default: begin
        state_d = ddf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddf_pkg::S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    exp_q       <= exp_d;
    pos_q       <= pos_d;
    neg_q       <= neg_d;
    lead_q      <= lead_d;
    pend_char_q <= pend_char_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The divider only reports a finished quotient while the sequencer waits for it.
  `DDF_ASSERT_SAME(a_done_in_div, div_res.done, state_q == ddf_pkg::S_DIV, "divider done outside wait")
  // A start pulse is only issued while a character is being worked on.
  `DDF_ASSERT_SAME(a_start_in_div, start_q, state_q == ddf_pkg::S_DIV, "divider start outside wait")
  // Taking a character that is not the final one leaves the item in progress, unless
  // the final character moved into the output register at that same edge.
  `DDF_ASSERT_NEXT(a_no_early_idle, out_valid_o && out_ready_i && !out_data_o.last, state_q != ddf_pkg::S_IDLE || out_valid_o, "item ended early")

endmodule

// File: tb/sv/decimal_display_formatter_tb.sv
// Self-checking testbench for the decimal display formatter: random and directed numbers, scoreboard.

// Scoreboard: turns every accepted number beat into the characters the block
// must produce and checks each output beat against the oldest one waiting.
class char_scoreboard;
  localparam logic [31:0] DIV_U10 = 32'd1_000_000_000;
  localparam logic [31:0] DIV_U5  = 32'd10_000;
  localparam logic [31:0] DIV_S6  = 32'd100_000;

  ddf_pkg::out_beat_t expected_chars[$];
  int unsigned mismatches;
  int unsigned unexpected;
  int unsigned reported;
  int unsigned chars_checked;
  int unsigned u10_numbers;
  int unsigned u5_numbers;
  int unsigned s6_numbers;
  int unsigned ignored_numbers;

  function new();
    mismatches      = 0;
    unexpected      = 0;
    reported        = 0;
    chars_checked   = 0;
    u10_numbers     = 0;
    u5_numbers      = 0;
    s6_numbers      = 0;
    ignored_numbers = 0;
  endfunction

  // Format one number the way the display expects it and queue its characters.
  function void note_number(ddf_pkg::in_beat_t beat);
    logic [31:0] rem;
    logic [31:0] div;
    logic [31:0] quot;
    int          count;
    bit          negative;
    bit          blanking;
    ddf_pkg::out_beat_t ch;
    negative = 1'b0;
    blanking = 1'b1;
    case (beat.command)
      ddf_pkg::CMD_U10: begin
        div   = DIV_U10;
        count = 10;
        rem   = beat.value;
        u10_numbers++;
      end
      ddf_pkg::CMD_U5: begin
        div   = DIV_U5;
        count = 5;
        rem   = beat.value;
        u5_numbers++;
      end
      ddf_pkg::CMD_S6: begin
        div      = DIV_S6;
        count    = 6;
        negative = beat.value[31];
        rem      = negative ? (32'd0 - beat.value) : beat.value;
        s6_numbers++;
      end
      default: begin
        // The unused command produces nothing at all.
        ignored_numbers++;
        return;
      end
    endcase
    for (int k = 0; k < count; k++) begin
      quot = rem / div;
      if (!blanking || quot != 32'd0 || k == count - 1) begin
        blanking     = 1'b0;
        // Oversized leading quotients wrap to 8 bits, just as the divider's q_low does.
        ch.character = ddf_pkg::CHAR_ZERO + quot[7:0];
      end else begin
        ch.character = negative ? ddf_pkg::CHAR_MINUS : ddf_pkg::CHAR_SPACE;
      end
      ch.position = k[3:0];
      ch.last     = (k == count - 1);
      expected_chars.push_back(ch);
      rem = rem % div;
      div = div / 32'd10;
      if (div == 32'd0) div = 32'd1;
    end
  endfunction

  // Compare one output beat, field by field, with the oldest expected character.
  function void check_char(ddf_pkg::out_beat_t got);
    ddf_pkg::out_beat_t want;
    if (expected_chars.size() == 0) begin
      unexpected++;
      if (reported < 10) begin
        reported++;
        $display("unexpected character beat: char=0x%02h pos=%0d last=%0b",
                 got.character, got.position, got.last);
      end
      return;
    end
    want = expected_chars.pop_front();
    chars_checked++;
    if (got.character !== want.character || got.position !== want.position ||
        got.last !== want.last) begin
      mismatches++;
      if (reported < 10) begin
        reported++;
        $display("character mismatch: expected char=0x%02h pos=%0d last=%0b, got char=0x%02h pos=%0d last=%0b",
                 want.character, want.position, want.last,
                 got.character, got.position, got.last);
      end
    end
  endfunction

  function int unsigned pending();
    return expected_chars.size();
  endfunction
endclass

module decimal_display_formatter_tb;
  // The reserved fourth command code, which the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Worst case: 430 numbers of ten characters, each character taking a full divider pass
  // plus the longest output stall, plus the longest input gaps. Taken several times over.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // Longer than one full ten-character number takes without output stalls.
  localparam int unsigned SETTLE_CYCLES = 400;

  localparam int unsigned RANDOM_NUMBERS = 405;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  ddf_pkg::in_beat_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  ddf_pkg::out_beat_t out_data_o;

  char_scoreboard sb;
  int unsigned    cycle_count = 0;

  decimal_display_formatter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog. If the run has not wrapped up by the limit, something is stuck.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("decimal_display_formatter_tb: errors");
    $finish;
  end

  // Monitor both channels at the clock edge. Values read here are the ones that were
  // stable before the edge, so every beat is seen exactly as the block saw it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_number(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_char(out_data_o);
    end
  end

  // Input gaps: mostly none or a few cycles, now and then a long pause.
  function automatic int unsigned input_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 30);
    return $urandom_range(40, 200);
  endfunction

  // Length of a stretch with the output ready high. The rare long stretch has no stalls.
  function automatic int unsigned ready_run();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 60);
    return $urandom_range(200, 400);
  endfunction

  // Length of an output stall. Long ones can outlast a whole divider pass.
  function automatic int unsigned stall_run();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] ten_to(input int unsigned n);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < n; i++) p = p * 32'd10;
    return p;
  endfunction

  function automatic ddf_pkg::in_beat_t make_number(input logic [1:0] cmd,
                                                    input logic [31:0] value);
    ddf_pkg::in_beat_t b;
    b.command = cmd;
    b.value   = value;
    return b;
  endfunction

  // Random number beat. Values are drawn from several shapes so that blanking,
  // boundaries around powers of ten, negatives and oversized leads all come up often.
  function automatic ddf_pkg::in_beat_t random_number();
    ddf_pkg::in_beat_t b;
    int unsigned       pick;
    logic [31:0]       p;
    pick = $urandom_range(0, 19);
    if (pick < 6)       b.command = ddf_pkg::CMD_U10;
    else if (pick < 12) b.command = ddf_pkg::CMD_U5;
    else if (pick < 19) b.command = ddf_pkg::CMD_S6;
    else                b.command = CMD_UNUSED;
    case ($urandom_range(0, 8))
      0, 1: b.value = $urandom;
      2:    b.value = $urandom_range(0, 99999);
      3: begin
        p       = ten_to($urandom_range(0, 9));
        b.value = p + $urandom_range(0, 2) - 32'd1;
      end
      4:    b.value = 32'd0 - $urandom_range(1, 199999);
      5: begin
        b.value = $urandom_range(0, 2_000_000);
        if ($urandom_range(0, 1) == 1) b.value = 32'd0 - b.value;
      end
      6:    b.value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      default: b.value = $urandom >> $urandom_range(0, 31);
    endcase
    return b;
  endfunction

  // Present one number beat after a random gap and hold it until the block takes it.
  // Valid stays high across back-to-back beats, so it is never lowered and raised
  // in the same time step.
  task automatic send_number(input ddf_pkg::in_beat_t beat);
    int unsigned gap;
    gap = input_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every queued character has come out. The first edge
  // lets the monitor record a beat accepted at the edge this task was called on.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Output side pacing: alternate ready and stall stretches of random length.
  initial begin : out_pacer
    int unsigned hold;
    bit          level;
    hold  = 0;
    level = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0) begin
        level = !level;
        hold  = level ? ready_run() : stall_run();
      end
      out_ready_i <= level;
      hold--;
    end
  end

  initial begin : main
    ddf_pkg::in_beat_t directed[$];
    ddf_pkg::in_beat_t beat;
    int unsigned       counted;
    int unsigned       failures;

    sb = new();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unsigned ten characters: zero, one, the largest word, and the edges of the top digit.
    directed.push_back(make_number(ddf_pkg::CMD_U10, 32'd0));
    directed.push_back(make_number(ddf_pkg::CMD_U10, 32'd1));
    directed.push_back(make_number(ddf_pkg::CMD_U10, 32'hFFFF_FFFF));
    directed.push_back(make_number(ddf_pkg::CMD_U10, 32'd1_000_000_000));
    directed.push_back(make_number(ddf_pkg::CMD_U10, 32'd999_999_999));
    directed.push_back(make_number(ddf_pkg::CMD_U10, 32'd4_000_000_000));
    // Unsigned five characters, including leads that overflow the digit range
    // and one that wraps around to look like a zero.
    directed.push_back(make_number(ddf_pkg::CMD_U5, 32'd0));
    directed.push_back(make_number(ddf_pkg::CMD_U5, 32'd9999));
    directed.push_back(make_number(ddf_pkg::CMD_U5, 32'd10000));
    directed.push_back(make_number(ddf_pkg::CMD_U5, 32'd99999));
    directed.push_back(make_number(ddf_pkg::CMD_U5, 32'd100000));
    directed.push_back(make_number(ddf_pkg::CMD_U5, 32'd2_560_000));
    directed.push_back(make_number(ddf_pkg::CMD_U5, 32'hFFFF_FFFF));
    directed.push_back(make_number(ddf_pkg::CMD_U5, 32'd12345));
    // Signed six characters: zero, minus one, minus-blanking, both extremes of the word,
    // and magnitudes that overflow the leading digit.
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'd0));
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'hFFFF_FFFF));
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'd0 - 32'd1234));
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'd99999));
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'd0 - 32'd99999));
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'd100000));
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'd1_000_000));
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'h7FFF_FFFF));
    directed.push_back(make_number(ddf_pkg::CMD_S6, 32'h8000_0000));
    // The unused command must be swallowed without output.
    directed.push_back(make_number(CMD_UNUSED, 32'd12345));
    directed.push_back(make_number(CMD_UNUSED, 32'hFFFF_FFFF));

    foreach (directed[i]) send_number(directed[i]);

    // Hold the sender back until the directed characters have all come out.
    wait_drained();

    counted = 0;
    while (counted < RANDOM_NUMBERS) begin
      beat = random_number();
      send_number(beat);
      if (beat.command != CMD_UNUSED) counted++;
      // An occasional full drain mid-run, so the block also restarts from idle.
      if ($urandom_range(0, 99) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.pending() != 0)
      $display("%0d expected characters never arrived", sb.pending());
    failures = sb.mismatches + sb.unexpected + sb.pending();

    $display("Run covered %0d ten-char, %0d five-char and %0d signed numbers, %0d ignored beats.",
             sb.u10_numbers, sb.u5_numbers, sb.s6_numbers, sb.ignored_numbers);
    $display("%0d character beats checked, %0d mismatched, %0d unexpected, in %0d cycles.",
             sb.chars_checked, sb.mismatches, sb.unexpected, cycle_count);

    if (failures == 0) begin
      $display("decimal_display_formatter_tb: clean");
    end else begin
      $display("decimal_display_formatter_tb: errors");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/ddf_pkg.sv
rtl/ddf_div.sv
rtl/decimal_display_formatter.sv
tb/sv/decimal_display_formatter_tb.sv
